/* rtl/core/csdo_pkg.sv */
// Shared types and constants for the CANopen SDO client and PDO receiver
package csdo_pkg;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // read completion codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_VALUE   = 2'd1,
        EV_ABORT   = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

    // configuration register indexes
    localparam logic REG_NODE    = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // register widths and reset values
    localparam int NODE_W = 7;
    localparam int TICK_W = 8;
    localparam logic [NODE_W-1:0] NODE_RESET    = 7'd1;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 8'd50;

    // function codes, identifier bits 10..7
    localparam logic [3:0] FC_TPDO1 = 4'h3;   // 0x180
    localparam logic [3:0] FC_TSDO  = 4'hB;   // 0x580
    localparam logic [3:0] FC_RSDO  = 4'hC;   // 0x600

    // sdo command bytes
    localparam logic [7:0] CMD_DOWNLOAD = 8'h22;
    localparam logic [7:0] CMD_UPLOAD   = 8'h40;
    localparam logic [7:0] CMD_ABORT    = 8'h80;
    localparam logic [7:0] SIZE_1BYTE   = 8'h0F;
    localparam logic [7:0] SIZE_2BYTE   = 8'h0B;
    localparam logic [7:0] SIZE_4BYTE   = 8'h03;

    // object dictionary entries watched in responses
    localparam logic [15:0] OD_STATUS   = 16'h6041;
    localparam logic [15:0] OD_POSITION = 16'h6064;

    // frame length
    localparam logic [3:0] TX_LENGTH = 4'd8;
    localparam logic [3:0] PDO_MIN_LENGTH = 4'd6;

    // status word bit for target reached
    localparam int TARGET_BIT = 10;

    // stream widths
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 168;
    localparam int OUT_USER_W = 3;

endpackage

/* rtl/core/canopen_sdo_client_and_pdo_receiver_top.sv */
// CANopen expedited SDO client and TPDO1 receiver for one drive node
// a request passes the input register, then the result register
// throughput: one request per cycle unless the result stream stalls
// the input register lets a new request enter while the previous result waits
// reset: stream and link state cleared, node number 1 and timeout 50 ticks
// no clearing pass after reset, requests are taken from the first cycle
module canopen_sdo_client_and_pdo_receiver_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic                                 cfg_addr,
    input  logic [7:0]                           cfg_data,
    // request stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // frame_id, frame_length, frame_payload, od_index, od_subindex,
    // write_value, write_size, zero pad
    input  logic [csdo_pkg::IN_DATA_W-1:0]       s_tdata,
    // operation
    input  logic [1:0]                           s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tx_id, tx_length, tx_payload, read_value, drive_status,
    // drive_position, target_reached, read_pending, zero pad
    output logic [csdo_pkg::OUT_DATA_W-1:0]      m_tdata,
    // tx_valid, read_event
    output logic [csdo_pkg::OUT_USER_W-1:0]      m_tuser
);

    // configuration registers
    logic [csdo_pkg::NODE_W-1:0] node_reg;
    logic [csdo_pkg::TICK_W-1:0] timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg    <= csdo_pkg::NODE_RESET;
            timeout_reg <= csdo_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                csdo_pkg::REG_NODE:    node_reg    <= cfg_data[csdo_pkg::NODE_W-1:0];
                csdo_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // input register stage
    logic                            in_valid_reg;
    logic [csdo_pkg::IN_DATA_W-1:0]  in_data_reg;
    csdo_pkg::op_t                   in_op_reg;
    logic                            advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
            in_op_reg   <= csdo_pkg::op_t'(s_tuser);
        end
    end

    // request field unpacking
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [15:0] od_index;
    logic [7:0]  od_subindex;
    logic [31:0] write_value;
    logic [2:0]  write_size;

    assign frame_id      = in_data_reg[10:0];
    assign frame_length  = in_data_reg[14:11];
    assign frame_payload = in_data_reg[78:15];
    assign od_index      = in_data_reg[94:79];
    assign od_subindex   = in_data_reg[102:95];
    assign write_value   = in_data_reg[134:103];
    assign write_size    = in_data_reg[137:135];

    // link state
    logic                        waiting_reg,   waiting_next;
    logic [15:0]                 aw_index_reg,  aw_index_next;
    logic [7:0]                  aw_sub_reg,    aw_sub_next;
    logic [csdo_pkg::TICK_W-1:0] count_reg,     count_next;
    logic [15:0]                 status_reg,    status_next;
    logic [31:0]                 position_reg,  position_next;

    // result fields
    logic                        tx_valid;
    logic [10:0]                 tx_id;
    logic [3:0]                  tx_length;
    logic [63:0]                 tx_payload;
    csdo_pkg::event_t            read_event;
    logic [31:0]                 read_value;

    // response decode
    logic [7:0]                  rsp_cmd;
    logic [15:0]                 rsp_index;
    logic [7:0]                  rsp_sub;
    logic [31:0]                 rsp_data;
    logic                        rsp_match;
    logic                        node_hit;
    logic [7:0]                  dl_cmd;
    logic [csdo_pkg::TICK_W-1:0] count_inc;

    assign rsp_cmd   = frame_payload[7:0];
    assign rsp_index = frame_payload[23:8];
    assign rsp_sub   = frame_payload[31:24];
    assign rsp_data  = frame_payload[63:32];
    assign rsp_match = waiting_reg && (rsp_index == aw_index_reg) && (rsp_sub == aw_sub_reg);
    assign node_hit  = (frame_id[6:0] == node_reg);
    assign count_inc = (count_reg == {csdo_pkg::TICK_W{1'b1}}) ? count_reg
                                                                : count_reg + 1'b1;

    // download command with size code
    always_comb
    begin
        case (write_size)
            3'd1:    dl_cmd = csdo_pkg::CMD_DOWNLOAD | csdo_pkg::SIZE_1BYTE;
            3'd2:    dl_cmd = csdo_pkg::CMD_DOWNLOAD | csdo_pkg::SIZE_2BYTE;
            3'd4:    dl_cmd = csdo_pkg::CMD_DOWNLOAD | csdo_pkg::SIZE_4BYTE;
            default: dl_cmd = csdo_pkg::CMD_DOWNLOAD;
        endcase
    end

    // request processing
    always_comb
    begin
        waiting_next  = waiting_reg;
        aw_index_next = aw_index_reg;
        aw_sub_next   = aw_sub_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        position_next = position_reg;
        tx_valid      = 1'b0;
        tx_id         = 11'd0;
        tx_length     = 4'd0;
        tx_payload    = 64'd0;
        read_event    = csdo_pkg::EV_NONE;
        read_value    = 32'd0;
        case (in_op_reg)
            csdo_pkg::OP_FRAME:
            begin
                if (node_hit && frame_id[10:7] == csdo_pkg::FC_TSDO)
                begin
                    if (rsp_cmd == csdo_pkg::CMD_ABORT)
                    begin
                        if (rsp_match)
                        begin
                            waiting_next = 1'b0;
                            read_event   = csdo_pkg::EV_ABORT;
                        end
                    end
                    else
                    begin
                        if (rsp_match)
                        begin
                            waiting_next = 1'b0;
                            read_event   = csdo_pkg::EV_VALUE;
                            read_value   = rsp_data;
                        end
                        if (rsp_index == csdo_pkg::OD_STATUS && rsp_sub == 8'd0)
                            status_next = rsp_data[15:0];
                        else if (rsp_index == csdo_pkg::OD_POSITION && rsp_sub == 8'd0)
                            position_next = rsp_data;
                    end
                end
                else if (node_hit && frame_id[10:7] == csdo_pkg::FC_TPDO1)
                begin
                    if (frame_length >= csdo_pkg::PDO_MIN_LENGTH)
                    begin
                        status_next   = frame_payload[15:0];
                        position_next = frame_payload[47:16];
                    end
                end
            end
            csdo_pkg::OP_WRITE:
            begin
                tx_valid   = 1'b1;
                tx_id      = {csdo_pkg::FC_RSDO, node_reg};
                tx_length  = csdo_pkg::TX_LENGTH;
                tx_payload = {write_value, od_subindex, od_index, dl_cmd};
            end
            csdo_pkg::OP_READ:
            begin
                tx_valid      = 1'b1;
                tx_id         = {csdo_pkg::FC_RSDO, node_reg};
                tx_length     = csdo_pkg::TX_LENGTH;
                tx_payload    = {32'd0, od_subindex, od_index, csdo_pkg::CMD_UPLOAD};
                waiting_next  = 1'b1;
                aw_index_next = od_index;
                aw_sub_next   = od_subindex;
                count_next    = '0;
            end
            csdo_pkg::OP_TICK:
            begin
                if (waiting_reg)
                begin
                    count_next = count_inc;
                    if (count_inc >= timeout_reg)
                    begin
                        waiting_next = 1'b0;
                        read_event   = csdo_pkg::EV_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
    end

    // state update on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg  <= 1'b0;
            aw_index_reg <= 16'd0;
            aw_sub_reg   <= 8'd0;
            count_reg    <= '0;
            status_reg   <= 16'd0;
            position_reg <= 32'd0;
        end
        else if (advance)
        begin
            waiting_reg  <= waiting_next;
            aw_index_reg <= aw_index_next;
            aw_sub_reg   <= aw_sub_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    // result register
    logic                             out_valid_reg;
    logic [csdo_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic [csdo_pkg::OUT_USER_W-1:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, waiting_next, status_next[csdo_pkg::TARGET_BIT],
                             position_next, status_next, read_value,
                             tx_payload, tx_length, tx_id};
            out_user_reg <= {read_event, tx_valid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTH
    // a finished read never leaves the wait armed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2:1] != csdo_pkg::EV_NONE |-> !m_tdata[160])
        else $error("read finished while still pending");

    // target reached follows the status word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[159] == m_tdata[111 + csdo_pkg::TARGET_BIT])
        else $error("target reached differs from status bit");

    // transmitted frames are full length and carry the RSDO function code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[14:11] == csdo_pkg::TX_LENGTH
                                  && m_tdata[10:7] == csdo_pkg::FC_RSDO)
        else $error("bad transmit frame header");

    // a processed request always produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request lost its result");

    // pending wait only ends through an event
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && waiting_reg && !waiting_next |-> read_event != csdo_pkg::EV_NONE)
        else $error("wait ended without an event");
`endif

endmodule

/* test/canopen_sdo_client_and_pdo_receiver_top_tb.sv */
// Self-checking testbench for the CANopen SDO client and TPDO1 receiver
`timescale 1ns / 1ps

module canopen_sdo_client_and_pdo_receiver_top_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;

    // response command bytes sent back by the drive
    localparam logic [7:0] RSP_UPLOAD_4 = 8'h43;
    localparam logic [7:0] RSP_UPLOAD_2 = 8'h4B;
    localparam logic [7:0] RSP_UPLOAD_1 = 8'h4F;
    localparam logic [7:0] RSP_DOWNLOAD = 8'h60;

    // one request as it travels on the input stream
    typedef struct packed {
        csdo_pkg::op_t op;
        logic [10:0]   fid;
        logic [3:0]    flen;
        logic [63:0]   payload;
        logic [15:0]   od_index;
        logic [7:0]    od_sub;
        logic [31:0]   wval;
        logic [2:0]    wsize;
    } link_req_t;

    // one result of the link
    typedef struct packed {
        logic             tx_valid;
        logic [10:0]      tx_id;
        logic [3:0]       tx_len;
        logic [63:0]      tx_pay;
        csdo_pkg::event_t rd_event;
        logic [31:0]      rd_value;
        logic [15:0]      status;
        logic [31:0]      position;
        logic             target;
        logic             pending;
    } link_res_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic                            cfg_addr = csdo_pkg::REG_NODE;
    logic [7:0]                      cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [csdo_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                      s_tuser = csdo_pkg::OP_FRAME;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [csdo_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [csdo_pkg::OUT_USER_W-1:0] m_tuser;

    canopen_sdo_client_and_pdo_receiver_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // link model state and its copy of the registers
    logic [csdo_pkg::NODE_W-1:0] node_id = csdo_pkg::NODE_RESET;
    logic [csdo_pkg::TICK_W-1:0] tick_limit = csdo_pkg::TIMEOUT_RESET;
    logic              awaiting = 1'b0;
    logic [15:0]       want_index = '0;
    logic [7:0]        want_sub = '0;
    logic [7:0]        tick_count = '0;
    logic [15:0]       model_status = '0;
    logic [31:0]       actual_pos = '0;

    link_req_t request_q[$];
    link_res_t expected_q[$];

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int errors = 0;
    int n_queued = 0;
    int n_in = 0;
    int n_out = 0;
    int n_tx = 0;
    int n_event[4] = '{0, 0, 0, 0};
    int tx_gap = 0;
    int rx_stall = 0;
    int quiet_cycles = 0;

    // expected result of one request, advances the model state
    function automatic link_res_t predict_link(link_req_t r);
        link_res_t  res;
        logic [7:0]  cmd;
        logic [15:0] ri;
        logic [7:0]  rs;
        logic [31:0] data;
        logic        match;
        res = '0;
        res.rd_event = csdo_pkg::EV_NONE;
        case (r.op)
            csdo_pkg::OP_FRAME:
            begin
                if (r.fid[6:0] == node_id) begin
                    if (r.fid == {csdo_pkg::FC_TSDO, node_id}) begin
                        cmd   = r.payload[7:0];
                        ri    = r.payload[23:8];
                        rs    = r.payload[31:24];
                        data  = r.payload[63:32];
                        match = awaiting && ri == want_index && rs == want_sub;
                        if (cmd == csdo_pkg::CMD_ABORT) begin
                            if (match) begin
                                awaiting = 1'b0;
                                res.rd_event = csdo_pkg::EV_ABORT;
                            end
                        end
                        else begin
                            if (match) begin
                                awaiting = 1'b0;
                                res.rd_event = csdo_pkg::EV_VALUE;
                                res.rd_value = data;
                            end
                            if (ri == csdo_pkg::OD_STATUS && rs == 8'd0)
                                model_status = data[15:0];
                            else if (ri == csdo_pkg::OD_POSITION && rs == 8'd0)
                                actual_pos = data;
                        end
                    end
                    else if (r.fid[10:7] == csdo_pkg::FC_TPDO1
                             && r.flen >= csdo_pkg::PDO_MIN_LENGTH) begin
                        model_status = r.payload[15:0];
                        actual_pos   = r.payload[47:16];
                    end
                end
            end
            csdo_pkg::OP_WRITE:
            begin
                cmd = csdo_pkg::CMD_DOWNLOAD;
                if (r.wsize == 3'd1)
                    cmd = cmd | csdo_pkg::SIZE_1BYTE;
                else if (r.wsize == 3'd2)
                    cmd = cmd | csdo_pkg::SIZE_2BYTE;
                else if (r.wsize == 3'd4)
                    cmd = cmd | csdo_pkg::SIZE_4BYTE;
                res.tx_valid = 1'b1;
                res.tx_id    = {csdo_pkg::FC_RSDO, node_id};
                res.tx_len   = csdo_pkg::TX_LENGTH;
                res.tx_pay   = {r.wval, r.od_sub, r.od_index, cmd};
            end
            csdo_pkg::OP_READ:
            begin
                res.tx_valid = 1'b1;
                res.tx_id    = {csdo_pkg::FC_RSDO, node_id};
                res.tx_len   = csdo_pkg::TX_LENGTH;
                res.tx_pay   = {32'd0, r.od_sub, r.od_index, csdo_pkg::CMD_UPLOAD};
                awaiting   = 1'b1;
                want_index = r.od_index;
                want_sub   = r.od_sub;
                tick_count = '0;
            end
            default:
            begin
                if (awaiting) begin
                    if (tick_count != 8'hFF)
                        tick_count = tick_count + 8'd1;
                    if (tick_count >= tick_limit) begin
                        awaiting = 1'b0;
                        res.rd_event = csdo_pkg::EV_TIMEOUT;
                    end
                end
            end
        endcase
        res.status   = model_status;
        res.position = actual_pos;
        res.target   = model_status[csdo_pkg::TARGET_BIT];
        res.pending  = awaiting;
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // request builders, fields that do not matter carry random noise
    function automatic link_req_t rand_req();
        link_req_t r;
        r.op       = csdo_pkg::op_t'($urandom_range(0, 3));
        r.fid      = 11'($urandom);
        r.flen     = 4'($urandom);
        r.payload  = {$urandom, $urandom};
        r.od_index = 16'($urandom);
        r.od_sub   = 8'($urandom);
        r.wval     = $urandom;
        r.wsize    = 3'($urandom);
        return r;
    endfunction

    function automatic link_req_t op_req(csdo_pkg::op_t op, logic [15:0] idx,
                                         logic [7:0] sub);
        link_req_t r;
        r = rand_req();
        r.op       = op;
        r.od_index = idx;
        r.od_sub   = sub;
        return r;
    endfunction

    function automatic link_req_t frame_req(logic [10:0] fid, logic [3:0] flen,
                                            logic [63:0] pay);
        link_req_t r;
        r = rand_req();
        r.op      = csdo_pkg::OP_FRAME;
        r.fid     = fid;
        r.flen    = flen;
        r.payload = pay;
        return r;
    endfunction

    function automatic link_req_t sdo_rsp(logic [7:0] cmd, logic [15:0] idx, logic [7:0] sub,
                                          logic [31:0] val);
        return frame_req({csdo_pkg::FC_TSDO, node_id}, 4'($urandom), {val, sub, idx, cmd});
    endfunction

    function automatic logic [6:0] other_node();
        logic [6:0] n;
        do
            n = 7'($urandom);
        while (n == node_id);
        return n;
    endfunction

    function automatic logic [7:0] pick_cmd();
        case ($urandom_range(0, 4))
            0: return RSP_UPLOAD_4;
            1: return RSP_UPLOAD_2;
            2: return RSP_UPLOAD_1;
            3: return RSP_DOWNLOAD;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic link_req_t filler();
        case ($urandom_range(0, 4))
            0: return op_req(csdo_pkg::OP_TICK, 16'($urandom), 8'($urandom));
            1: return frame_req({4'($urandom), other_node()}, 4'($urandom),
                                {$urandom, $urandom});
            2: return op_req(csdo_pkg::OP_WRITE, 16'($urandom), 8'($urandom));
            3: return frame_req({4'($urandom), node_id}, 4'($urandom), {$urandom, $urandom});
            default: return rand_req();
        endcase
    endfunction

    task automatic push(link_req_t r);
        request_q.push_back(r);
        n_queued++;
    endtask

    // one random exchange: read sequences half the time, the rest single frames, writes or noise
    task automatic add_scenario();
        logic [15:0] idx;
        logic [7:0]  sub;
        int          n;
        case ($urandom_range(0, 3))
            0:
            begin
                idx = csdo_pkg::OD_STATUS;
                sub = 8'd0;
            end
            1:
            begin
                idx = csdo_pkg::OD_POSITION;
                sub = 8'd0;
            end
            default:
            begin
                idx = 16'($urandom);
                sub = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
            end
        endcase
        case ($urandom_range(0, 11))
            0, 1, 2, 3:
            begin
                push(op_req(csdo_pkg::OP_READ, idx, sub));
                repeat ($urandom_range(0, 2)) push(filler());
                case ($urandom_range(0, 5))
                    0: push(sdo_rsp(csdo_pkg::CMD_ABORT, idx, sub, $urandom));
                    1:
                    begin
                        push(sdo_rsp(pick_cmd(), idx ^ (16'd1 << $urandom_range(0, 15)), sub,
                                     $urandom));
                        push(sdo_rsp(pick_cmd(), idx, sub, $urandom));
                    end
                    2:
                    begin
                        push(sdo_rsp(csdo_pkg::CMD_ABORT, idx,
                                     sub ^ 8'($urandom_range(1, 255)), $urandom));
                        push(sdo_rsp(pick_cmd(), idx, sub, $urandom));
                    end
                    default: push(sdo_rsp(pick_cmd(), idx, sub, $urandom));
                endcase
            end
            4:
            begin
                push(op_req(csdo_pkg::OP_READ, idx, sub));
                if (tick_limit <= 8'd20)
                    n = $urandom_range(0, tick_limit + 2);
                else if ($urandom_range(0, 29) == 0)
                    n = tick_limit + 1;
                else
                    n = $urandom_range(0, 8);
                repeat (n) push(op_req(csdo_pkg::OP_TICK, 16'($urandom), 8'($urandom)));
            end
            5: push(frame_req({csdo_pkg::FC_TPDO1, node_id}, 4'($urandom),
                              {$urandom, $urandom}));
            6: push(op_req(csdo_pkg::OP_WRITE, 16'($urandom), 8'($urandom)));
            7: push(sdo_rsp(pick_cmd(), idx, sub, $urandom));
            8:
            begin
                push(op_req(csdo_pkg::OP_READ, idx, sub));
                push(op_req(csdo_pkg::OP_READ, ~idx, sub));
                push(sdo_rsp(pick_cmd(), idx, sub, $urandom));
                push(sdo_rsp(pick_cmd(), ~idx, sub, $urandom));
            end
            default: push(filler());
        endcase
    endtask

    task automatic write_reg(logic addr, logic [7:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= val;
        if (addr == csdo_pkg::REG_NODE)
            node_id = val[csdo_pkg::NODE_W-1:0];
        else
            tick_limit = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued request has been answered
    task automatic drain();
        while (!(request_q.size() == 0 && !s_tvalid && expected_q.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count, bit tx_idle, bit rx_idle);
        int stop_at;
        @(negedge clk);
        tx_idle_on = tx_idle;
        rx_idle_on = rx_idle;
        stop_at = n_queued + count;
        while (n_queued < stop_at)
            add_scenario();
        drain();
    endtask

    // request driver
    always @(posedge clk) begin
        link_req_t r;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else if (!(s_tvalid && !s_tready)) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (request_q.size() > 0) begin
                r = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.op;
                s_tdata  <= {6'd0, r.wsize, r.wval, r.od_sub, r.od_index, r.payload,
                             r.flen, r.fid};
                tx_gap = tx_idle_on ? $urandom_range(0, 5) : 0;
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and checker
    always @(posedge clk) begin
        link_req_t r;
        link_res_t e;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                r.op       = csdo_pkg::op_t'(s_tuser);
                r.fid      = s_tdata[10:0];
                r.flen     = s_tdata[14:11];
                r.payload  = s_tdata[78:15];
                r.od_index = s_tdata[94:79];
                r.od_sub   = s_tdata[102:95];
                r.wval     = s_tdata[134:103];
                r.wsize    = s_tdata[137:135];
                expected_q.push_back(predict_link(r));
                n_in++;
            end
            if (m_tvalid && m_tready) begin
                n_out++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result tdata %h tuser %h", $time, m_tdata, m_tuser);
                end
                else begin
                    e = expected_q.pop_front();
                    check_field("tx_valid", e.tx_valid, m_tuser[0]);
                    check_field("read_event", e.rd_event, m_tuser[2:1]);
                    check_field("tx_id", e.tx_id, m_tdata[10:0]);
                    check_field("tx_length", e.tx_len, m_tdata[14:11]);
                    check_field("tx_payload", e.tx_pay, m_tdata[78:15]);
                    check_field("read_value", e.rd_value, m_tdata[110:79]);
                    check_field("drive_status", e.status, m_tdata[126:111]);
                    check_field("drive_position", e.position, m_tdata[158:127]);
                    check_field("target_reached", e.target, m_tdata[159]);
                    check_field("read_pending", e.pending, m_tdata[160]);
                    n_tx += e.tx_valid;
                    n_event[e.rd_event]++;
                end
                rx_stall = rx_idle_on ? $urandom_range(0, 5) : 0;
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on stalled handshakes
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset registers, node 1, timeout 50
        push(op_req(csdo_pkg::OP_WRITE, 16'h0000, 8'h00));
        request_q[$].wsize = 3'd1;
        request_q[$].wval  = 32'h0000_0000;
        push(op_req(csdo_pkg::OP_WRITE, 16'hFFFF, 8'hFF));
        request_q[$].wsize = 3'd2;
        request_q[$].wval  = 32'h7FFF_FFFF;
        push(op_req(csdo_pkg::OP_WRITE, 16'h1234, 8'h01));
        request_q[$].wsize = 3'd4;
        request_q[$].wval  = 32'h8000_0000;
        push(op_req(csdo_pkg::OP_WRITE, 16'h6040, 8'h00));
        request_q[$].wsize = 3'd0;
        request_q[$].wval  = 32'hFFFF_FFFF;
        push(op_req(csdo_pkg::OP_WRITE, 16'h607A, 8'h00));
        request_q[$].wsize = 3'd7;
        push(op_req(csdo_pkg::OP_WRITE, 16'h6081, 8'h00));
        request_q[$].wsize = 3'd3;
        // tick while idle
        push(op_req(csdo_pkg::OP_TICK, 16'h0, 8'h0));
        // status read answered, target reached bit set
        push(op_req(csdo_pkg::OP_READ, csdo_pkg::OD_STATUS, 8'd0));
        push(sdo_rsp(RSP_UPLOAD_2, csdo_pkg::OD_STATUS, 8'd0, 32'h0000_0437));
        // position read aborted, no update
        push(op_req(csdo_pkg::OP_READ, csdo_pkg::OD_POSITION, 8'd0));
        push(sdo_rsp(csdo_pkg::CMD_ABORT, csdo_pkg::OD_POSITION, 8'd0, 32'h1234_5678));
        // unsolicited position, status with nonzero subindex
        push(sdo_rsp(RSP_UPLOAD_4, csdo_pkg::OD_POSITION, 8'd0, 32'hFFFF_FFFF));
        push(sdo_rsp(RSP_UPLOAD_2, csdo_pkg::OD_STATUS, 8'd1, 32'h0000_FFFF));
        // tpdo1 too short, minimum length, longest code
        push(frame_req({csdo_pkg::FC_TPDO1, node_id}, 4'd5, {$urandom, $urandom}));
        push(frame_req({csdo_pkg::FC_TPDO1, node_id}, 4'd6, {$urandom, $urandom}));
        push(frame_req({csdo_pkg::FC_TPDO1, node_id}, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
        // frames for another node or with unknown identifiers
        push(frame_req({csdo_pkg::FC_TSDO, 7'd2}, 4'd8,
                       {32'h0, 8'h00, csdo_pkg::OD_STATUS, RSP_UPLOAD_2}));
        push(frame_req({csdo_pkg::FC_TPDO1, 7'd2}, 4'd8, 64'h0));
        push(frame_req(11'h000, 4'd8, {$urandom, $urandom}));
        push(frame_req(11'h7FF, 4'd8, {$urandom, $urandom}));
        push(frame_req({csdo_pkg::FC_RSDO, node_id}, 4'd8,
                       {32'h0, 8'h00, csdo_pkg::OD_STATUS, RSP_UPLOAD_2}));
        // new read replaces the pending one
        push(op_req(csdo_pkg::OP_READ, 16'h1000, 8'h01));
        push(op_req(csdo_pkg::OP_READ, 16'h2000, 8'h02));
        push(sdo_rsp(RSP_UPLOAD_4, 16'h1000, 8'h01, $urandom));
        push(sdo_rsp(RSP_UPLOAD_4, 16'h2000, 8'h02, $urandom));
        drain();
        run_random(200, 1'b1, 1'b1);

        // highest node, shortest timeout
        write_reg(csdo_pkg::REG_NODE, 8'd127);
        write_reg(csdo_pkg::REG_TIMEOUT, 8'd1);
        @(negedge clk);
        push(op_req(csdo_pkg::OP_READ, csdo_pkg::OD_POSITION, 8'd0));
        push(op_req(csdo_pkg::OP_TICK, 16'h0, 8'h0));
        push(op_req(csdo_pkg::OP_TICK, 16'h0, 8'h0));
        push(op_req(csdo_pkg::OP_WRITE, 16'hFFFF, 8'hFF));
        drain();
        run_random(200, 1'b1, 1'b1);

        // unused top bit of the node register, longest timeout
        write_reg(csdo_pkg::REG_NODE, 8'h85);
        write_reg(csdo_pkg::REG_TIMEOUT, 8'd255);
        @(negedge clk);
        push(op_req(csdo_pkg::OP_READ, 16'h6061, 8'd0));
        repeat (256) push(op_req(csdo_pkg::OP_TICK, 16'($urandom), 8'($urandom)));
        drain();
        run_random(150, 1'b0, 1'b0);

        write_reg(csdo_pkg::REG_NODE, 8'($urandom_range(2, 126)));
        write_reg(csdo_pkg::REG_TIMEOUT, 8'($urandom_range(2, 12)));
        run_random(100, 1'b1, 1'b1);

        write_reg(csdo_pkg::REG_NODE, 8'd1);
        write_reg(csdo_pkg::REG_TIMEOUT, 8'd3);
        run_random(150, 1'b1, 1'b0);

        write_reg(csdo_pkg::REG_NODE, 8'hFF);
        write_reg(csdo_pkg::REG_TIMEOUT, 8'd20);
        run_random(150, 1'b0, 1'b1);

        $display("requests %0d, results %0d, frames sent %0d", n_in, n_out, n_tx);
        $display("reads returned %0d, aborted %0d, timed out %0d",
                 n_event[csdo_pkg::EV_VALUE], n_event[csdo_pkg::EV_ABORT],
                 n_event[csdo_pkg::EV_TIMEOUT]);
        if (errors == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
